[rtl/cell_balance_selector_assert.svh]
// Assertion macros for the cell balance selector.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef CELL_BALANCE_SELECTOR_ASSERT_SVH
`define CELL_BALANCE_SELECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during rst.
`define CBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cell_balance_selector check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define CBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cell_balance_selector check failed");
`else
`define CBS_ASSERT_NOW(label, ante, cons)
`define CBS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/cbs_pkg.sv]
package cbs_pkg;

  localparam int NUM_CELLS = 5;
  localparam int CODE_W    = 14;
  localparam int CUR_W     = 16;
  localparam int GAIN_W    = 9;
  localparam int OFF_W     = 8;
  localparam int THR_W     = 16;
  localparam int MASK_W    = 5;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Cell voltage in uV: 511 * 16383 plus 128000 fits 25 signed bits.
  localparam int V_W = 25;
  // 5*v - sum spans twice 5 times the largest voltage: 28 signed bits.
  localparam int D_W = 28;

  localparam logic [GAIN_W-1:0] GAIN_RESET      = GAIN_W'(380);
  localparam logic [OFF_W-1:0]  OFFSET_RESET    = '0;
  localparam logic [THR_W-1:0]  THRESH_HI_RESET = THR_W'(10000);
  localparam logic [THR_W-1:0]  THRESH_LO_RESET = THR_W'(5000);
  localparam int                MV_TO_UV        = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_THRESH_HI = 3'd2,
    REG_THRESH_LO = 3'd3
  } reg_index_t;

  typedef logic signed [V_W-1:0] volt_t;
  typedef logic signed [D_W-1:0] dev_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_uv_per_lsb;
    logic [OFF_W-1:0]  offset_mv;
    logic [THR_W-1:0]  thresh_high_uv;
    logic [THR_W-1:0]  thresh_low_uv;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell1_code;
    logic [CODE_W-1:0] cell2_code;
    logic [CODE_W-1:0] cell3_code;
    logic [CODE_W-1:0] cell4_code;
    logic [CODE_W-1:0] cell5_code;
    logic [CUR_W-1:0]  current_code;
  } sample_t;

  typedef struct packed {
    logic [MASK_W-1:0] balance_mask;
    logic              mask_written;
    logic [IDX_W-1:0]  top_cell;
    logic              charging;
  } result_t;

  // Times five as shift and add.
  function automatic dev_t times_five(input dev_t x);
    return (x <<< 2) + x;
  endfunction

endpackage

[rtl/cbs_lane.sv]
// One cell lane: voltage, then scaled deviation against the pack sum.
module cbs_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cbs_pkg::CODE_W-1:0]    code,
  input  cbs_pkg::cfg_t                 cfg,
  input  cbs_pkg::dev_t                 sum,
  output cbs_pkg::volt_t                volt,
  output cbs_pkg::dev_t                 dev
);

  cbs_pkg::volt_t gain_s;
  cbs_pkg::volt_t code_s;
  cbs_pkg::volt_t off_s;
  cbs_pkg::volt_t volt_next;
  cbs_pkg::dev_t  volt_ext;

  always_comb begin
    gain_s    = cbs_pkg::volt_t'({1'b0, cfg.gain_uv_per_lsb});
    code_s    = cbs_pkg::volt_t'({1'b0, code});
    off_s     = cbs_pkg::volt_t'(signed'(cfg.offset_mv));
    volt_next = gain_s * code_s + off_s * cbs_pkg::volt_t'(cbs_pkg::MV_TO_UV);
    volt_ext  = cbs_pkg::dev_t'(volt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      volt <= volt_next;
      dev  <= cbs_pkg::times_five(volt_ext) - sum;
    end
  end

endmodule

[rtl/cbs_merge.sv]
// Merge: pick the largest deviation (lowest index on ties), apply hysteresis.
module cbs_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cbs_pkg::dev_t       dev [cbs_pkg::NUM_CELLS],
  input  logic                charging,
  input  cbs_pkg::cfg_t       cfg,
  output cbs_pkg::result_t    result
);

  logic [cbs_pkg::MASK_W-1:0] held_mask;
  logic [cbs_pkg::MASK_W-1:0] held_mask_next;
  logic                       written;
  logic [cbs_pkg::IDX_W-1:0]  idx_a, idx_b, idx_c, top;
  cbs_pkg::dev_t              val_a, val_b, val_c, best;
  cbs_pkg::dev_t              lim_hi, lim_lo;

  always_comb begin
    // Pairwise tree; the right side wins only when strictly larger.
    idx_a = (dev[1] > dev[0]) ? 3'd1 : 3'd0;
    val_a = (dev[1] > dev[0]) ? dev[1] : dev[0];
    idx_b = (dev[3] > dev[2]) ? 3'd3 : 3'd2;
    val_b = (dev[3] > dev[2]) ? dev[3] : dev[2];
    idx_c = (val_b > val_a) ? idx_b : idx_a;
    val_c = (val_b > val_a) ? val_b : val_a;
    top   = (dev[4] > val_c) ? 3'd4 : idx_c;
    best  = (dev[4] > val_c) ? dev[4] : val_c;

    lim_hi = cbs_pkg::times_five(cbs_pkg::dev_t'({1'b0, cfg.thresh_high_uv}));
    lim_lo = cbs_pkg::times_five(cbs_pkg::dev_t'({1'b0, cfg.thresh_low_uv}));

    held_mask_next = held_mask;
    written        = 1'b1;
    priority if (!charging) begin
      held_mask_next = '0;
    end else if (best > lim_hi) begin
      held_mask_next = cbs_pkg::MASK_W'(1) << top;
    end else if (best < lim_lo) begin
      held_mask_next = '0;
    end else begin
      written = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask <= '0;
    end else if (en) begin
      held_mask <= held_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.balance_mask <= held_mask_next;
      result.mask_written <= written;
      result.top_cell     <= top;
      result.charging     <= charging;
    end
  end

endmodule

[rtl/cell_balance_selector.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// sample   | sample_valid/sample_ready  | cbs_pkg::sample_t, 5 codes + current
// result   | result_valid/result_ready  | cbs_pkg::result_t, mask and status
// cfg      | cfg_valid/cfg_ready        | cfg_index (3 b), cfg_data (16 b)
//
// Three register stages, loaded in order as the pipe advances:
// lane voltages (gain * code + offset), 5*v - sum per lane, compare tree and hysteresis.
// result_valid rises when a sample reaches the third stage; one sample per cycle while
// the result side keeps up. A stalled result holds every stage and drops sample_ready.
// rst clears the valid pipe and the held mask and loads the register defaults.
// cfg is always ready; writes to an unused index are dropped.
module cell_balance_selector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  cbs_pkg::sample_t                  sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output cbs_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "cell_balance_selector_assert.svh"

  cbs_pkg::cfg_t  cfg;
  logic           advance;
  logic           s1_valid, s2_valid;
  logic           s1_charging, s2_charging;
  logic           charging_in;
  logic [cbs_pkg::CODE_W-1:0] codes [cbs_pkg::NUM_CELLS];
  cbs_pkg::volt_t volts [cbs_pkg::NUM_CELLS];
  cbs_pkg::dev_t  devs  [cbs_pkg::NUM_CELLS];
  cbs_pkg::dev_t  sum;

  // Config writes land at once; the user must write only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_uv_per_lsb <= cbs_pkg::GAIN_RESET;
      cfg.offset_mv       <= cbs_pkg::OFFSET_RESET;
      cfg.thresh_high_uv  <= cbs_pkg::THRESH_HI_RESET;
      cfg.thresh_low_uv   <= cbs_pkg::THRESH_LO_RESET;
    end else if (cfg_valid) begin
      unique case (cbs_pkg::reg_index_t'(cfg_index))
        cbs_pkg::REG_GAIN:      cfg.gain_uv_per_lsb <= cfg_data[cbs_pkg::GAIN_W-1:0];
        cbs_pkg::REG_OFFSET:    cfg.offset_mv       <= cfg_data[cbs_pkg::OFF_W-1:0];
        cbs_pkg::REG_THRESH_HI: cfg.thresh_high_uv  <= cfg_data[cbs_pkg::THR_W-1:0];
        cbs_pkg::REG_THRESH_LO: cfg.thresh_low_uv   <= cfg_data[cbs_pkg::THR_W-1:0];
        default: begin
          // Drop writes to unmapped indices.
        end
      endcase
    end
  end

  // The whole pipe moves together whenever the output register is free or
  // being emptied this cycle.
  assign advance      = !result_valid || result_ready;
  assign sample_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= sample_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  // Deadband: a raw current of +1 or -1 counts as zero, so charging means
  // strictly above one.
  assign charging_in = signed'(sample.current_code) > cbs_pkg::CUR_W'(signed'(1));

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_charging <= charging_in;
      s2_charging <= s1_charging;
    end
  end

  assign codes[0] = sample.cell1_code;
  assign codes[1] = sample.cell2_code;
  assign codes[2] = sample.cell3_code;
  assign codes[3] = sample.cell4_code;
  assign codes[4] = sample.cell5_code;

  // Pack sum of the stage-1 voltages, shared by all lanes in stage 2.
  always_comb begin
    sum = '0;
    for (int i = 0; i < cbs_pkg::NUM_CELLS; i++) begin
      sum = sum + cbs_pkg::dev_t'(volts[i]);
    end
  end

  for (genvar g = 0; g < cbs_pkg::NUM_CELLS; g++) begin : g_lane
    cbs_lane u_lane (
      .clk  (clk),
      .en   (advance),
      .code (codes[g]),
      .cfg  (cfg),
      .sum  (sum),
      .volt (volts[g]),
      .dev  (devs[g])
    );
  end

  // Only real transactions touch the held mask.
  cbs_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (advance && s2_valid),
    .dev      (devs),
    .charging (s2_charging),
    .cfg      (cfg),
    .result   (result)
  );

  `CBS_ASSERT_NOW(a_mask_onehot, result_valid, $onehot0(result.balance_mask))
  `CBS_ASSERT_NOW(a_idle_clears, result_valid && !result.charging,
                  result.balance_mask == '0 && result.mask_written)
  `CBS_ASSERT_NOW(a_set_matches_top,
                  result_valid && result.mask_written && result.balance_mask != '0,
                  result.balance_mask == (cbs_pkg::MASK_W'(1) << result.top_cell))
  `CBS_ASSERT_NEXT(a_stall_holds_pipe, result_valid && !result_ready && s2_valid,
                   s2_valid && result_valid)

endmodule
